FILE: rtl/stsk_pkg.sv
// Shared constants for the Stirling-number core: field widths, the prime
// modulus, the reduction constant and the query selector codes.
// No dependencies.
`default_nettype none

package stsk_pkg;

  // Field widths
  localparam int OP_W  = 2;
  localparam int IDX_W = 12;
  localparam int CNT_W = 30;

  // Prime modulus and reduction constant floor(2^43 / MODULUS)
  localparam logic [CNT_W-1:0] MODULUS    = 30'd998244353;
  localparam int               MU_W       = 14;
  localparam logic [MU_W-1:0]  BARRETT_MU = 14'd8811;

  // Query selector codes
  localparam logic [OP_W-1:0] OP_STIRLING = 2'd0;
  localparam logic [OP_W-1:0] OP_SURJ     = 2'd1;
  localparam logic [OP_W-1:0] OP_PSUM     = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/stsk_ifs.sv
// Valid/ready channel interfaces for the query input and the count output.
// Depends on stsk_pkg.
`default_nettype none

interface stsk_in_if;
  import stsk_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [IDX_W-1:0] n_items;
  logic [IDX_W-1:0] m_boxes;

  modport source (output valid, op, n_items, m_boxes, input ready);
  modport sink   (input valid, op, n_items, m_boxes, output ready);
endinterface

interface stsk_out_if;
  import stsk_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] count;

  modport source (output valid, count, input ready);
  modport sink   (input valid, count, output ready);
endinterface

`default_nettype wire

FILE: rtl/stsk_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module stsk_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/stsk_mulmod.sv
// Multi-cycle modular multiplier: 12-bit by 30-bit product reduced modulo
// the prime with a Barrett estimate and a final correction.
// Depends on stsk_pkg.
`default_nettype none

module stsk_mulmod (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [stsk_pkg::IDX_W-1:0] a,
  input  wire logic [stsk_pkg::CNT_W-1:0] b,
  output      logic                       done,
  output      logic [stsk_pkg::CNT_W-1:0] res
);
  import stsk_pkg::*;

  localparam int PROD_W = IDX_W + CNT_W;           // 42
  localparam int Q_W    = PROD_W - (CNT_W - 1);    // 13
  localparam int T_W    = Q_W + MU_W;              // 27
  localparam int QP_W   = Q_W + CNT_W;             // 43

  typedef enum logic [2:0] {
    MS_IDLE, MS_MUL, MS_QEST, MS_QP, MS_SUB, MS_FIX
  } mstage_t;

  mstage_t             stage_r, stage_nxt;
  logic                done_r, done_nxt;
  logic [IDX_W-1:0]    a_r, a_nxt;
  logic [CNT_W-1:0]    b_r, b_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [T_W-1:0]      t_r, t_nxt;
  logic [QP_W-1:0]     qp_r, qp_nxt;
  logic [31:0]         rem_r, rem_nxt;
  logic [CNT_W-1:0]    res_r, res_nxt;
  logic [QP_W-1:0]     diff;
  logic [31:0]         two_p;

  assign two_p = {1'b0, MODULUS, 1'b0};
  assign diff  = {1'b0, prod_r} - qp_r;

  // Advance one reduction step per cycle
  always_comb begin
    stage_nxt = stage_r;
    done_nxt  = 1'b0;
    a_nxt     = a_r;
    b_nxt     = b_r;
    prod_nxt  = prod_r;
    t_nxt     = t_r;
    qp_nxt    = qp_r;
    rem_nxt   = rem_r;
    res_nxt   = res_r;
    if (start) begin
      a_nxt     = a;
      b_nxt     = b;
      stage_nxt = MS_MUL;
    end else begin
      unique case (stage_r)
        MS_IDLE: ;
        MS_MUL: begin
          prod_nxt  = a_r * b_r;
          stage_nxt = MS_QEST;
        end
        MS_QEST: begin
          t_nxt     = prod_r[PROD_W-1 -: Q_W] * BARRETT_MU;
          stage_nxt = MS_QP;
        end
        MS_QP: begin
          qp_nxt    = t_r[T_W-1 -: Q_W] * MODULUS;
          stage_nxt = MS_SUB;
        end
        MS_SUB: begin
          // Estimate is low by at most two multiples of the modulus
          rem_nxt   = diff[31:0];
          stage_nxt = MS_FIX;
        end
        MS_FIX: begin
          if (rem_r >= two_p) begin
            res_nxt = CNT_W'(rem_r - two_p);
          end else if (rem_r >= {2'b00, MODULUS}) begin
            res_nxt = CNT_W'(rem_r - {2'b00, MODULUS});
          end else begin
            res_nxt = rem_r[CNT_W-1:0];
          end
          done_nxt  = 1'b1;
          stage_nxt = MS_IDLE;
        end
        default: stage_nxt = MS_IDLE;
      endcase
    end
  end

  // Hold stage control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= MS_IDLE;
      done_r  <= 1'b0;
    end else begin
      stage_r <= stage_nxt;
      done_r  <= done_nxt;
    end
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    prod_r <= prod_nxt;
    t_r    <= t_nxt;
    qp_r   <= qp_nxt;
    rem_r  <= rem_nxt;
    res_r  <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

`default_nettype wire

FILE: rtl/stirling_second_kind_mod_prime_core.sv
// Top level of the Stirling-number core: query sequencer, row store and
// the shared modular multiplier.
// Depends on stsk_pkg, stsk_ifs, stsk_ram and stsk_mulmod.
`default_nettype none

// Takes one query (op, n_items, m_boxes) at a time and returns one count
// modulo 998244353: op 0 gives S(n,m), op 1 gives S(n,m)*m!, op 2 gives
// the sum of S(n,i) for i = 1..m. Out-of-range queries (m = 0, n = 0,
// op = 3, sizes at or beyond MAX_N, or m > n for ops 0 and 1) return 0.
// A valid query rebuilds row n of the triangle in the row store, one cell
// at a time, through a single multiply-reduce unit, with columns up to
// L = min(m,n); op 2 then ends with a final summation and op 1 with
// factorial scaling. The longest query is n = m = 4095. The input is
// ready only while no query is in progress; a finished count waits in an
// output register while the next query is taken. The row store needs no
// clearing after reset.
module stirling_second_kind_mod_prime_core #(
  parameter int MAX_N = 4096
) (
  input  wire logic clk,
  input  wire logic rst_n,
  stsk_in_if.sink   in_ch,
  stsk_out_if.source out_ch
);
  import stsk_pkg::*;

  localparam int          AW     = $clog2(MAX_N);
  localparam int unsigned MAXN_U = MAX_N;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLR, ST_ROW, ST_RWAIT, ST_LOAD, ST_MUL,
    ST_FWAIT, ST_FGET, ST_FMUL, ST_DONE
  } state_t;

  function automatic logic [CNT_W-1:0] mod_add(input logic [CNT_W-1:0] x,
                                               input logic [CNT_W-1:0] y);
    logic [CNT_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, MODULUS}) begin
      return CNT_W'(s - {1'b0, MODULUS});
    end
    return s[CNT_W-1:0];
  endfunction

  state_t           state_r, state_nxt;
  logic [OP_W-1:0]  op_r, op_nxt;
  logic [IDX_W-1:0] n_r, n_nxt;
  logic [IDX_W-1:0] m_r, m_nxt;
  logic [IDX_W-1:0] lim_r, lim_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0] acc_r, acc_nxt;
  logic [AW-1:0]    raddr_r, raddr_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] out_count_r, out_count_nxt;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [CNT_W-1:0] ram_wdata;
  logic [CNT_W-1:0] ram_rdata;

  logic             mul_start;
  logic [IDX_W-1:0] mul_a;
  logic [CNT_W-1:0] mul_b;
  logic             mul_done;
  logic [CNT_W-1:0] mul_res;

  logic             query_ok;
  logic [IDX_W-1:0] row_top;

  // Screen the incoming query
  always_comb begin
    query_ok = (in_ch.op <= OP_PSUM) && (in_ch.n_items != '0) &&
               (in_ch.m_boxes != '0) &&
               (32'(in_ch.n_items) < MAXN_U) && (32'(in_ch.m_boxes) < MAXN_U) &&
               ((in_ch.op == OP_PSUM) || (in_ch.m_boxes <= in_ch.n_items));
  end

  assign row_top = (i_r < lim_r) ? i_r : lim_r;

  // Sequence clear, row rebuild and final pass
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    n_nxt         = n_r;
    m_nxt         = m_r;
    lim_nxt       = lim_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    acc_nxt       = acc_r;
    raddr_nxt     = raddr_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    out_count_nxt = out_count_r;
    ram_we        = 1'b0;
    ram_waddr     = AW'(j_r);
    ram_wdata     = '0;
    mul_start     = 1'b0;
    mul_a         = j_r;
    mul_b         = ram_rdata;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          op_nxt  = in_ch.op;
          n_nxt   = in_ch.n_items;
          m_nxt   = in_ch.m_boxes;
          lim_nxt = (in_ch.m_boxes < in_ch.n_items) ? in_ch.m_boxes : in_ch.n_items;
          j_nxt   = '0;
          acc_nxt = '0;
          state_nxt = query_ok ? ST_CLR : ST_DONE;
        end
      end
      ST_CLR: begin
        // Clear columns 0..lim and seed S(1,1)
        ram_we    = 1'b1;
        ram_wdata = (j_r == IDX_W'(1)) ? CNT_W'(1) : '0;
        if (j_r == lim_r) begin
          i_nxt = IDX_W'(2);
          if (n_r == IDX_W'(1)) begin
            acc_nxt   = '0;
            k_nxt     = IDX_W'(1);
            raddr_nxt = (op_r == OP_PSUM) ? AW'(1) : AW'(lim_r);
            state_nxt = ST_FWAIT;
          end else begin
            state_nxt = ST_ROW;
          end
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end
      ST_ROW: begin
        j_nxt     = row_top;
        raddr_nxt = AW'(row_top);
        state_nxt = ST_RWAIT;
      end
      ST_RWAIT: state_nxt = ST_LOAD;
      ST_LOAD: begin
        // Start j*S(i-1,j) and fetch S(i-1,j-1)
        mul_start = 1'b1;
        mul_a     = j_r;
        mul_b     = ram_rdata;
        raddr_nxt = AW'(j_r - IDX_W'(1));
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (mul_done) begin
          ram_we    = 1'b1;
          ram_wdata = mod_add(ram_rdata, mul_res);
          if (j_r == IDX_W'(1)) begin
            if (i_r == n_r) begin
              acc_nxt   = '0;
              k_nxt     = IDX_W'(1);
              raddr_nxt = (op_r == OP_PSUM) ? AW'(1) : AW'(lim_r);
              state_nxt = ST_FWAIT;
            end else begin
              i_nxt     = i_r + IDX_W'(1);
              state_nxt = ST_ROW;
            end
          end else begin
            // Old S(i-1,j-1) is on the read port: feed the next cell
            j_nxt     = j_r - IDX_W'(1);
            raddr_nxt = AW'(j_r - IDX_W'(2));
            mul_start = 1'b1;
            mul_a     = j_r - IDX_W'(1);
            mul_b     = ram_rdata;
          end
        end
      end
      ST_FWAIT: state_nxt = ST_FGET;
      ST_FGET: begin
        case (op_r)
          OP_PSUM: begin
            acc_nxt = mod_add(acc_r, ram_rdata);
            if (k_r == lim_r) begin
              state_nxt = ST_DONE;
            end else begin
              k_nxt     = k_r + IDX_W'(1);
              raddr_nxt = AW'(k_r + IDX_W'(1));
              state_nxt = ST_FWAIT;
            end
          end
          OP_SURJ: begin
            acc_nxt = ram_rdata;
            if (m_r == IDX_W'(1)) begin
              state_nxt = ST_DONE;
            end else begin
              k_nxt     = IDX_W'(2);
              mul_start = 1'b1;
              mul_a     = IDX_W'(2);
              mul_b     = ram_rdata;
              state_nxt = ST_FMUL;
            end
          end
          default: begin
            acc_nxt   = ram_rdata;
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_FMUL: begin
        // Scale by 2, 3, ... m
        if (mul_done) begin
          acc_nxt = mul_res;
          if (k_r == m_r) begin
            state_nxt = ST_DONE;
          end else begin
            k_nxt     = k_r + IDX_W'(1);
            mul_start = 1'b1;
            mul_a     = k_r + IDX_W'(1);
            mul_b     = mul_res;
          end
        end
      end
      ST_DONE: begin
        // Hand the count to the output register once it is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = acc_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    n_r         <= n_nxt;
    m_r         <= m_nxt;
    lim_r       <= lim_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    k_r         <= k_nxt;
    acc_r       <= acc_nxt;
    raddr_r     <= raddr_nxt;
    out_count_r <= out_count_nxt;
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.count = out_count_r;

  stsk_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_N)
  ) u_row_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (raddr_r),
    .rdata (ram_rdata)
  );

  stsk_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  // Multiplier results arrive only while the sequencer waits for them
  a_mul_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == ST_MUL || state_r == ST_FMUL))
    else $error("multiplier result arrived in an unexpected state");

  // Row writes stay inside the columns in use
  a_write_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (j_r <= lim_r))
    else $error("row store write beyond the active columns");

  // Cell updates never reach column zero
  a_cell_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (j_r != '0))
    else $error("cell update at column zero");

  // Published counts are fully reduced
  a_count_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_count_r < MODULUS))
    else $error("output count not reduced");

  // A new count is published only from the hand-off state
  a_publish_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("output published outside the hand-off state");

endmodule

`default_nettype wire
